### design/a256c_pkg.sv
// Package for the AES-256 counter-mode block cipher: types, S-box and round helpers.
// No dependencies; used by the key cell, the round cell and the top level in design/.
`default_nettype none
package a256c_pkg;

   localparam int NumRounds  = 14;
   localparam int BlockBits  = 128;
   localparam int KeyBits    = 256;
   localparam int WordBits   = 64;
   localparam int CsrIdxBits = 3;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxBits-1:0] RegKey0   = 3'd0;
   localparam logic [CsrIdxBits-1:0] RegKey1   = 3'd1;
   localparam logic [CsrIdxBits-1:0] RegKey2   = 3'd2;
   localparam logic [CsrIdxBits-1:0] RegKey3   = 3'd3;
   localparam logic [CsrIdxBits-1:0] RegNonce0 = 3'd4;
   localparam logic [CsrIdxBits-1:0] RegNonce1 = 3'd5;

   typedef logic [BlockBits-1:0] block_type;
   typedef logic [7:0]           byte_type;

   // Per-item side data riding alongside the cipher state.
   typedef struct packed {
      logic [WordBits-1:0] data0;
      logic [WordBits-1:0] data1;
      logic                last;
   } side_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type gmul2(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block sits at bits [127-8i -: 8] (big-endian).
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[BlockBits-1-8*i -: 8];
   endfunction

   // One full round: SubBytes, ShiftRows, optional MixColumns.
   function automatic block_type round_fn(input block_type s, input logic mix);
      block_type o;
      byte_type  t [16];
      byte_type  a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r+4*c] = sbox(get_byte(s, r + 4*((c+r) & 3)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (mix) begin
            o[BlockBits-1-8*(4*c)   -: 8] = a0 ^ al ^ gmul2(a0 ^ a1);
            o[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ al ^ gmul2(a1 ^ a2);
            o[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ al ^ gmul2(a2 ^ a3);
            o[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ al ^ gmul2(a3 ^ a0);
         end else begin
            o[BlockBits-1-8*(4*c)   -: 8] = a0;
            o[BlockBits-1-8*(4*c+1) -: 8] = a1;
            o[BlockBits-1-8*(4*c+2) -: 8] = a2;
            o[BlockBits-1-8*(4*c+3) -: 8] = a3;
         end
      end
      return o;
   endfunction

   // SubWord of a 32-bit key word, with optional RotWord.
   function automatic logic [31:0] sub_word(input logic [31:0] w, input logic rot);
      logic [31:0] v;
      v = rot ? {w[23:0], w[31:24]} : w;
      return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
   endfunction

endpackage
`default_nettype wire

### design/a256c_key_cell.sv
// One key-schedule cell: derives four round-key words from the previous eight.
// Depends on a256c_pkg.
`default_nettype none
module a256c_key_cell #(
   parameter int Step = 1
) (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire logic [255:0] prev_keys,
   output logic      [255:0] next_keys_ff
);
   localparam logic [7:0] Rcon = 8'(1 << ((Step - 1) / 2));
   localparam bit         Odd  = (Step % 2) == 1;

   logic [31:0]  w   [12];
   logic [31:0]  tmp;
   logic [255:0] next_keys_in;

   // Words 0..7 are the previous window; 8..11 are derived.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         w[i] = prev_keys[255-32*i -: 32];
      end
      if (Odd) begin
         tmp = a256c_pkg::sub_word(w[7], 1'b1) ^ {Rcon, 24'h0};
      end else begin
         tmp = a256c_pkg::sub_word(w[7], 1'b0);
      end
      w[8]  = w[0] ^ tmp;
      w[9]  = w[1] ^ w[8];
      w[10] = w[2] ^ w[9];
      w[11] = w[3] ^ w[10];
      next_keys_in = {w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         next_keys_ff <= next_keys_in;
      end
   end
endmodule
`default_nettype wire

### design/a256c_round_cell.sv
// One cipher cell: an AES round (no MixColumns in the final cell) plus round-key add, with side data, registered.
// Depends on a256c_pkg.
`default_nettype none
module a256c_round_cell #(
   parameter bit Final = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  valid_prev,
   input  a256c_pkg::block_type       state_prev,
   input  a256c_pkg::side_type        side_prev,
   input  a256c_pkg::block_type       round_key,
   output logic                       valid_ff,
   output a256c_pkg::block_type       state_ff,
   output a256c_pkg::side_type        side_ff
);
   a256c_pkg::block_type state_in;

   // Round transform and key add.
   assign state_in = a256c_pkg::round_fn(state_prev, !Final) ^ round_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         side_ff  <= side_prev;
      end
   end
endmodule
`default_nettype wire

### design/aes256_ctr_block_cipher.sv
// Top level of the AES-256 counter-mode block cipher: registers, key chain, round chain.
// Depends on a256c_pkg, a256c_key_cell and a256c_round_cell.
//
//   Channel | Ports             | Direction | Contents
//   request | req_t*            | in        | data_word0, data_word1, block_index, last
//   result  | rsp_t*            | out       | result_word0, result_word1, last
//   config  | csr_*             | in        | six 64-bit registers, write only
//
// An accepted request item passes one input stage, 14 round cells and one output
// register; one item enters each cycle while the chain advances, which it does
// whenever the output stage is empty or being taken, so a stall on rsp freezes all
// but the key cells. Reset clears every valid bit. A key write settles along the key
// cells. Configuration must be written only while idle; the block does not enforce it.
`default_nettype none
module aes256_ctr_block_cipher #(
   parameter int Rounds = a256c_pkg::NumRounds
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,  // data_word0, data_word1, block_index
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [127:0] rsp_tdata,  // result_word0, result_word1
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [a256c_pkg::CsrIdxBits-1:0] csr_index,
   input  wire logic [63:0]  csr_wdata
);
   localparam int KeySteps = Rounds - 1;

   logic [63:0] key_ff [4];
   logic [63:0] nonce0_ff, nonce1_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce0_ff <= '0;
         nonce1_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            a256c_pkg::RegKey0:   key_ff[0] <= csr_wdata;
            a256c_pkg::RegKey1:   key_ff[1] <= csr_wdata;
            a256c_pkg::RegKey2:   key_ff[2] <= csr_wdata;
            a256c_pkg::RegKey3:   key_ff[3] <= csr_wdata;
            a256c_pkg::RegNonce0: nonce0_ff <= csr_wdata;
            a256c_pkg::RegNonce1: nonce1_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key chain: each cell slides the 256-bit window of key words on by four words.
   logic [255:0] keys [KeySteps+1];
   assign keys[0] = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};

   genvar k;
   generate
      for (k = 1; k <= KeySteps; k++) begin : g_key
         a256c_key_cell #(.Step(k)) u_key (
            .clock(clock), .load(1'b1),
            .prev_keys(keys[k-1]), .next_keys_ff(keys[k])
         );
      end
   endgenerate

   // Round key r: upper half of window r; the last round uses the lower half
   // of the final window.
   a256c_pkg::block_type rkey [Rounds+1];
   genvar r;
   generate
      for (r = 0; r <= Rounds; r++) begin : g_rk
         if (r < Rounds) begin : g_hi
            assign rkey[r] = keys[r][255:128];
         end else begin : g_lo
            assign rkey[r] = keys[Rounds-1][127:0];
         end
      end
   endgenerate

   // Chain flow control.
   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Input stage: counter block with initial key add.
   logic                 v   [Rounds+1];
   a256c_pkg::block_type st  [Rounds+1];
   a256c_pkg::side_type  sd  [Rounds+1];
   logic                 in_valid_ff;
   a256c_pkg::block_type in_state_ff;
   a256c_pkg::side_type  in_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_state_ff <= {nonce0_ff, nonce1_ff ^ req_tdata[191:128]} ^ rkey[0];
         in_side_ff  <= '{data0: req_tdata[63:0], data1: req_tdata[127:64],
                          last: req_tlast};
      end
   end

   assign v[0]  = in_valid_ff;
   assign st[0] = in_state_ff;
   assign sd[0] = in_side_ff;

   genvar c;
   generate
      for (c = 1; c <= Rounds; c++) begin : g_round
         a256c_round_cell #(.Final(c == Rounds)) u_round (
            .clock(clock), .reset(reset), .advance(advance),
            .valid_prev(v[c-1]), .state_prev(st[c-1]), .side_prev(sd[c-1]),
            .round_key(rkey[c]),
            .valid_ff(v[c]), .state_ff(st[c]), .side_ff(sd[c])
         );
      end
   endgenerate

   // Output register: keystream XOR data.
   logic [127:0] out_data_ff;
   logic         out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= v[Rounds];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {sd[Rounds].data1 ^ st[Rounds][63:0],
                         sd[Rounds].data0 ^ st[Rounds][127:64]};
         out_last_ff <= sd[Rounds].last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

### design/a256c_checker.sv
// Port-level checker for the AES-256 counter-mode block cipher, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module a256c_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic         rsp_tlast
);
   // A stalled result item holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Input is ready whenever the output stage is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with free output");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind aes256_ctr_block_cipher a256c_checker u_a256c_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the AES-256 counter-mode block cipher.
// It depends on a256c_pkg and aes256_ctr_block_cipher. It builds its own AES-256 keystream
// model, drives random and directed items with random gaps and stalls, and checks every result.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [a256c_pkg::CsrIdxBits-1:0] RegSpare6 = 3'd6;
   localparam logic [a256c_pkg::CsrIdxBits-1:0] RegSpare7 = 3'd7;
   localparam int NumRegs    = 6;
   localparam int StallLimit = 2000;
   localparam int DrainWait  = 40;

   typedef struct {
      logic [63:0] data0;
      logic [63:0] data1;
      logic [63:0] blk_num;
      logic        last;
   } block_item_type;

   typedef struct {
      logic [63:0] text0;
      logic [63:0] text1;
      logic        last;
   } cipher_out_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [a256c_pkg::CsrIdxBits-1:0] csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   aes256_ctr_block_cipher dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   block_item_type pending_blocks[$];
   cipher_out_type expected_text[$];
   logic [63:0] key_nonce_regs [NumRegs];
   logic [7:0]  sub_table [256];
   int          error_count = 0;
   int          send_gap = 0;
   int          take_gap = 0;
   int          quiet_cycles = 0;
   bit          heavy_idle = 1'b1;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = xtime(a);
      end
      return acc;
   endfunction

   // The substitution box from the field inverse followed by the affine map.
   function automatic void build_sub_table();
      logic [7:0] inv, res;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mult(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         res = 8'h63;
         for (int k = 0; k < 5; k++) res ^= (inv << k) | (inv >> (8 - k));
         sub_table[x] = res;
      end
   endfunction

   function automatic logic [31:0] sub_word32(input logic [31:0] w);
      return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
   endfunction

   // AES-256 encryption of one counter block; byte 0 sits in the top bits.
   function automatic logic [127:0] keystream_block(input logic [255:0] key,
                                                    input logic [127:0] ctr);
      logic [31:0]  sched [60];
      logic [31:0]  tw;
      logic [7:0]   rc;
      logic [7:0]   st [16];
      logic [7:0]   sh [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] rkey, outv;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) sched[i] = key[255-32*i -: 32];
      for (int i = 8; i < 60; i++) begin
         tw = sched[i-1];
         if (i % 8 == 0) begin
            tw = sub_word32({tw[23:0], tw[31:24]}) ^ {rc, 24'h0};
            rc = xtime(rc);
         end else if (i % 8 == 4) begin
            tw = sub_word32(tw);
         end
         sched[i] = sched[i-8] ^ tw;
      end
      rkey = {sched[0], sched[1], sched[2], sched[3]};
      for (int i = 0; i < 16; i++) st[i] = ctr[127-8*i -: 8] ^ rkey[127-8*i -: 8];
      for (int rnd = 1; rnd <= 14; rnd++) begin
         // SubBytes and ShiftRows together, then MixColumns except in the last round.
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               sh[r+4*c] = sub_table[st[r+4*((c+r)%4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
            if (rnd != 14) begin
               al = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
               st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
               st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
               st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end else begin
               st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
            end
         end
         rkey = {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
         for (int i = 0; i < 16; i++) st[i] ^= rkey[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) outv[127-8*i -: 8] = st[i];
      return outv;
   endfunction

   function automatic cipher_out_type predict_cipher(input block_item_type it);
      cipher_out_type res;
      logic [127:0] ks;
      ks = keystream_block({key_nonce_regs[0], key_nonce_regs[1], key_nonce_regs[2],
                            key_nonce_regs[3]},
                           {key_nonce_regs[4], key_nonce_regs[5] ^ it.blk_num});
      res.text0 = it.data0 ^ ks[127:64];
      res.text1 = it.data1 ^ ks[63:0];
      res.last  = it.last;
      return res;
   endfunction

   function automatic int draw_gap();
      if (heavy_idle && $urandom_range(0, 2) == 0) return $urandom_range(0, 17);
      return 0;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Request driver: holds an item until accepted, then waits its drawn gap.
   always @(posedge clock) begin
      block_item_type nxt;
      block_item_type sent;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            sent.data0 = req_tdata[63:0];
            sent.data1 = req_tdata[127:64];
            sent.blk_num = req_tdata[191:128];
            sent.last = req_tlast;
            expected_text.push_back(predict_cipher(sent));
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_blocks.size() > 0) begin
            nxt = pending_blocks.pop_front();
            req_tdata <= {nxt.blk_num, nxt.data1, nxt.data0};
            req_tlast <= nxt.last;
            req_tvalid <= 1'b1;
            send_gap <= draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: random back-pressure, checks each accepted item.
   always @(posedge clock) begin
      cipher_out_type exp_out;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected result %h last %b", $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               exp_out = expected_text.pop_front();
               if (rsp_tdata[63:0] !== exp_out.text0) begin
                  $display("%0t: result_word0 expected %h actual %h",
                           $time, exp_out.text0, rsp_tdata[63:0]);
                  error_count++;
               end
               if (rsp_tdata[127:64] !== exp_out.text1) begin
                  $display("%0t: result_word1 expected %h actual %h",
                           $time, exp_out.text1, rsp_tdata[127:64]);
                  error_count++;
               end
               if (rsp_tlast !== exp_out.last) begin
                  $display("%0t: last expected %b actual %b",
                           $time, exp_out.last, rsp_tlast);
                  error_count++;
               end
            end
            take_gap <= draw_gap();
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: work outstanding but no item moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_blocks.size() == 0 && expected_text.size() == 0 && !req_tvalid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("aes256_ctr_block_cipher: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [a256c_pkg::CsrIdxBits-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < NumRegs) key_nonce_regs[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_blocks.size() > 0 || req_tvalid || expected_text.size() > 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic queue_block(input logic [63:0] d0, input logic [63:0] d1,
                              input logic [63:0] num, input logic last);
      block_item_type it;
      it.data0 = d0; it.data1 = d1; it.blk_num = num; it.last = last;
      pending_blocks.push_back(it);
   endtask

   // Mostly well-formed runs of consecutive block numbers, the rest arbitrary items.
   task automatic queue_random(input int count);
      int run_len;
      logic [63:0] base;
      while (count > 0) begin
         if ($urandom_range(0, 3) != 0) begin
            run_len = $urandom_range(1, 16);
            base = ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 1000));
            for (int i = 0; i < run_len; i++)
               queue_block(rand64(), rand64(), base + i, i == run_len - 1);
            count -= run_len;
         end else begin
            queue_block(rand64(), rand64(), rand64(), $urandom_range(0, 1));
            count--;
         end
      end
   endtask

   task automatic load_regs(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] n0, input logic [63:0] n1);
      write_reg(a256c_pkg::RegKey0, k0);
      write_reg(a256c_pkg::RegKey1, k1);
      write_reg(a256c_pkg::RegKey2, k2);
      write_reg(a256c_pkg::RegKey3, k3);
      write_reg(a256c_pkg::RegNonce0, n0);
      write_reg(a256c_pkg::RegNonce1, n1);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      build_sub_table();
      for (int i = 0; i < NumRegs; i++) key_nonce_regs[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the all-zero reset configuration.
      queue_block('0, '0, '0, 1'b0);
      queue_block('1, '1, '1, 1'b1);
      queue_block('0, '1, 64'h8000_0000_0000_0000, 1'b1);
      queue_block('1, '0, 64'h1, 1'b0);
      for (int i = 0; i < 4; i++) queue_block(rand64(), rand64(), i, i == 3);
      wait_idle();

      // All-ones key and nonce, then writes past the last register that must not land.
      load_regs('1, '1, '1, '1, '1, '1);
      write_reg(RegSpare6, rand64());
      write_reg(RegSpare7, rand64());
      repeat (10) @(posedge clock);
      queue_block('0, '0, '0, 1'b1);
      queue_block('1, '1, '1, 1'b0);
      queue_block(rand64(), rand64(), '1, 1'b1);
      for (int i = 0; i < 6; i++) queue_block(rand64(), rand64(), rand64(), i[0]);
      wait_idle();

      // Random configurations, alternating traffic with random gaps and stalls and back-to-back traffic.
      for (int ph = 0; ph < 6; ph++) begin
         heavy_idle = ph[0];
         load_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         queue_random(85);
         wait_idle();
      end
      heavy_idle = 1'b1;
      load_regs('0, '1, '0, '1, '1, '0);
      queue_random(20);
      wait_idle();

      if (error_count == 0) begin
         $display("aes256_ctr_block_cipher: match");
      end else begin
         $display("aes256_ctr_block_cipher: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
